[rtl/core/ihb_pkg.sv]
// ----------------------------------------------------------------------------
// ihb_pkg
// Operation and status codes and fixed field widths shared by the indexed
// binary heap core and its rank compare unit.
// ----------------------------------------------------------------------------
package ihb_pkg;

	localparam int OP_W    = 2;
	localparam int ST_W    = 2;
	localparam int KEY_W   = 32;
	localparam int IDP_W   = 10;
	localparam int CNTP_W  = 11;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
	localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
	localparam logic [OP_W-1:0] OP_POP    = 2'd3;

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
	localparam logic [ST_W-1:0] ST_BADID  = 2'd3;

endpackage

[rtl/core/indexed_binary_heap_core.sv]
// ----------------------------------------------------------------------------
// indexed_binary_heap_core
// Indexed binary heap priority queue with insert, erase, update and pop.
// ----------------------------------------------------------------------------
// One operation is taken at a time and gives one result. The time an
// operation takes grows with the heap levels walked and is set by the
// one-read one-write heap memory, read once per cycle with registered data,
// and one shared rank compare.
// After reset and after every write of max_mode the presence flags are
// cleared by a pass over all ELEMENTS entries, during which in_ready stays low.
// ----------------------------------------------------------------------------
module indexed_binary_heap_core #(
	parameter int CAPACITY = 1024,
	parameter int ELEMENTS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [ihb_pkg::OP_W-1:0]         operation,
	input  logic [ihb_pkg::IDP_W-1:0]        element_id,
	input  logic signed [ihb_pkg::KEY_W-1:0] element_key,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ihb_pkg::IDP_W-1:0]        top_id,
	output logic signed [ihb_pkg::KEY_W-1:0] top_key,
	output logic [ihb_pkg::CNTP_W-1:0]       element_count,
	output logic [ihb_pkg::ST_W-1:0]         status,
	input  logic                             cfg_we,
	input  logic                             cfg_wdata
);

	localparam int SW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int IDW = $clog2(ELEMENTS);
	localparam int KW  = ihb_pkg::KEY_W;
	localparam int EW  = IDW + KW;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK  = 4'd1;
	localparam logic [3:0] S_ERS  = 4'd2;
	localparam logic [3:0] S_UPS  = 4'd3;
	localparam logic [3:0] S_POPR = 4'd4;
	localparam logic [3:0] S_LDE  = 4'd5;
	localparam logic [3:0] S_UP   = 4'd6;
	localparam logic [3:0] S_UPC  = 4'd7;
	localparam logic [3:0] S_DN   = 4'd8;
	localparam logic [3:0] S_DNL  = 4'd9;
	localparam logic [3:0] S_DNR  = 4'd10;
	localparam logic [3:0] S_DNM  = 4'd11;
	localparam logic [3:0] S_WR   = 4'd12;
	localparam logic [3:0] S_FIN  = 4'd13;

	logic [3:0]                 state_q;
	logic [ihb_pkg::OP_W-1:0]   op_q;
	logic [IDW-1:0]             id_q;
	logic signed [KW-1:0]       key_q;
	logic                       rng_q;
	logic [IDW-1:0]             e_id_q;
	logic signed [KW-1:0]       e_key_q;
	logic [IDW-1:0]             best_id_q;
	logic signed [KW-1:0]       best_key_q;
	logic [SW-1:0]              best_slot_q;
	logic                       best_e_q;
	logic [SW-1:0]              s_q;
	logic [SW-1:0]              l_q;
	logic                       second_q;
	logic [CW-1:0]              count_q;
	logic                       mode_q;
	logic                       clr_q;
	logic [IDW-1:0]             clr_idx_q;
	logic [ihb_pkg::IDP_W-1:0]  res_tid_q;
	logic signed [KW-1:0]       res_tkey_q;
	logic [ihb_pkg::ST_W-1:0]   res_st_q;
	logic                       out_valid_q;

	// memories
	logic [EW-1:0]  heap_mem [CAPACITY];
	logic [SW-1:0]  slot_mem [ELEMENTS];
	logic           pres_mem [ELEMENTS];
	logic [EW-1:0]  heap_rd_q;
	logic [SW-1:0]  slot_rd_q;
	logic           pres_rd_q;

	logic           heap_we, slot_we, pres_we, pres_wd;
	logic [SW-1:0]  heap_wa, heap_ra, slot_wd;
	logic [EW-1:0]  heap_wd;
	logic [IDW-1:0] slot_wa, pres_wa, pres_ra;

	logic [IDW+ihb_pkg::IDP_W-1:0] id_wide;
	logic           in_rng;
	logic [IDW-1:0] rd_id;
	logic signed [KW-1:0] rd_key;
	logic [SW-1:0]  p_slot;
	logic [CW:0]    l_ext, r_ext;
	logic           cmp_above;
	logic [IDW-1:0] cmp_a_id, cmp_b_id;
	logic signed [KW-1:0] cmp_a_key, cmp_b_key;

	assign id_wide = (IDW + ihb_pkg::IDP_W)'(element_id);
	assign in_rng  = id_wide < ELEMENTS;
	assign rd_id   = heap_rd_q[EW-1:KW];
	assign rd_key  = heap_rd_q[KW-1:0];
	assign p_slot  = (s_q - SW'(1)) >> 1;
	assign l_ext   = {(CW + 1 - SW)'(0), s_q} + {(CW + 1 - SW)'(0), s_q} + (CW + 1)'(1);
	assign r_ext   = {(CW + 1 - SW)'(0), l_q} + (CW + 1)'(1);

	assign in_ready = (state_q == S_IDLE) && !clr_q;

	// shared compare: sift-up pits the moving element against the parent,
	// sift-down pits each child against the best so far
	always_comb begin
		if (state_q == S_UPC) begin
			cmp_a_id  = e_id_q;
			cmp_a_key = e_key_q;
			cmp_b_id  = rd_id;
			cmp_b_key = rd_key;
		end else begin
			cmp_a_id  = rd_id;
			cmp_a_key = rd_key;
			cmp_b_id  = best_id_q;
			cmp_b_key = best_key_q;
		end
	end

	ihb_rank #(.IDW(IDW)) u_rank (
		.max_mode (mode_q),
		.a_id     (cmp_a_id),
		.a_key    (cmp_a_key),
		.b_id     (cmp_b_id),
		.b_key    (cmp_b_key),
		.above    (cmp_above)
	);

	always_comb begin
		heap_we = 1'b0;
		heap_wa = s_q;
		heap_wd = {e_id_q, e_key_q};
		heap_ra = '0;
		slot_we = 1'b0;
		slot_wa = e_id_q;
		slot_wd = s_q;
		pres_we = 1'b0;
		pres_wa = id_q;
		pres_wd = 1'b0;
		pres_ra = id_wide[IDW-1:0];
		unique case (state_q)
			S_CHK: begin
				heap_ra = '0;
				if (rng_q && op_q == ihb_pkg::OP_INSERT && !pres_rd_q
						&& count_q != CW'(CAPACITY)) begin
					pres_we = 1'b1;
					pres_wd = 1'b1;
				end
				if (rng_q && op_q == ihb_pkg::OP_ERASE && pres_rd_q) begin
					pres_we = 1'b1;
				end
			end
			S_ERS: heap_ra = count_q[SW-1:0];
			S_POPR: begin
				heap_ra = count_q[SW-1:0];
				pres_we = 1'b1;
				pres_wa = rd_id;
			end
			S_UP:  heap_ra = p_slot;
			S_UPC: begin
				if (cmp_above) begin
					heap_we = 1'b1;
					heap_wd = heap_rd_q;
					slot_we = 1'b1;
					slot_wa = rd_id;
				end
			end
			S_DN:  heap_ra = l_ext[SW-1:0];
			S_DNL: heap_ra = r_ext[SW-1:0];
			S_DNM: begin
				if (!best_e_q) begin
					heap_we = 1'b1;
					heap_wd = {best_id_q, best_key_q};
					slot_we = 1'b1;
					slot_wa = best_id_q;
				end
			end
			S_WR: begin
				heap_we = 1'b1;
				slot_we = 1'b1;
			end
			default: begin
			end
		endcase
		if (clr_q) begin
			pres_we = 1'b1;
			pres_wa = clr_idx_q;
			pres_wd = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (heap_we) heap_mem[heap_wa] <= heap_wd;
		heap_rd_q <= heap_mem[heap_ra];
	end

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_wa] <= slot_wd;
		slot_rd_q <= slot_mem[id_q];
	end

	always_ff @(posedge clk) begin
		if (pres_we) pres_mem[pres_wa] <= pres_wd;
		pres_rd_q <= pres_mem[pres_ra];
	end

	// presence clearing pass, restarted by every mode write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			mode_q    <= 1'b1;
		end else if (cfg_we) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			mode_q    <= cfg_wdata;
		end else if (clr_q) begin
			if (clr_idx_q == IDW'(ELEMENTS - 1)) clr_q <= 1'b0;
			clr_idx_q <= clr_idx_q + IDW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			out_valid_q   <= 1'b0;
			second_q      <= 1'b0;
			op_q          <= ihb_pkg::OP_INSERT;
			id_q          <= '0;
			key_q         <= '0;
			rng_q         <= 1'b0;
			e_id_q        <= '0;
			e_key_q       <= '0;
			best_id_q     <= '0;
			best_key_q    <= '0;
			best_slot_q   <= '0;
			best_e_q      <= 1'b0;
			s_q           <= '0;
			l_q           <= '0;
			res_tid_q     <= '0;
			res_tkey_q    <= '0;
			res_st_q      <= ihb_pkg::ST_OK;
			top_id        <= '0;
			top_key       <= '0;
			element_count <= '0;
			status        <= ihb_pkg::ST_OK;
		end else begin
			// a new result in S_FIN takes over the register in the same cycle
			if (out_valid_q && out_ready && state_q != S_FIN) out_valid_q <= 1'b0;
			if (cfg_we) count_q <= '0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						op_q    <= operation;
						id_q    <= id_wide[IDW-1:0];
						key_q   <= element_key;
						rng_q   <= in_rng;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					res_tid_q  <= '0;
					res_tkey_q <= '0;
					res_st_q   <= ihb_pkg::ST_OK;
					e_id_q     <= id_q;
					e_key_q    <= key_q;
					second_q   <= 1'b0;
					state_q    <= S_FIN;
					unique case (op_q)
						ihb_pkg::OP_INSERT: begin
							if (!rng_q || pres_rd_q) begin
								res_st_q <= ihb_pkg::ST_BADID;
							end else if (count_q == CW'(CAPACITY)) begin
								res_st_q <= ihb_pkg::ST_FULL;
							end else begin
								s_q     <= count_q[SW-1:0];
								count_q <= count_q + CW'(1);
								state_q <= S_UP;
							end
						end
						ihb_pkg::OP_ERASE: begin
							if (!rng_q || !pres_rd_q) begin
								res_st_q <= ihb_pkg::ST_BADID;
							end else begin
								count_q <= count_q - CW'(1);
								state_q <= S_ERS;
							end
						end
						ihb_pkg::OP_UPDATE: begin
							if (!rng_q || !pres_rd_q) begin
								res_st_q <= ihb_pkg::ST_BADID;
							end else begin
								second_q <= 1'b1;
								state_q  <= S_UPS;
							end
						end
						default: begin
							if (count_q == '0) begin
								res_st_q <= ihb_pkg::ST_EMPTY;
							end else begin
								count_q <= count_q - CW'(1);
								state_q <= S_POPR;
							end
						end
					endcase
				end
				S_ERS: begin
					s_q <= slot_rd_q;
					// erasing the last slot needs no sift
					if (CW'(slot_rd_q) == count_q) begin
						state_q <= S_FIN;
					end else begin
						second_q <= 1'b1;
						state_q  <= S_LDE;
					end
				end
				S_UPS: begin
					s_q     <= slot_rd_q;
					state_q <= S_UP;
				end
				S_POPR: begin
					res_tid_q  <= ihb_pkg::IDP_W'(rd_id);
					res_tkey_q <= rd_key;
					s_q        <= '0;
					if (count_q == '0) begin
						state_q <= S_FIN;
					end else begin
						second_q <= 1'b1;
						state_q  <= S_LDE;
					end
				end
				S_LDE: begin
					e_id_q  <= rd_id;
					e_key_q <= rd_key;
					state_q <= S_DN;
				end
				S_UP: begin
					if (s_q == '0) begin
						second_q <= 1'b0;
						state_q  <= second_q ? S_DN : S_WR;
					end else begin
						state_q <= S_UPC;
					end
				end
				S_UPC: begin
					if (cmp_above) begin
						s_q     <= p_slot;
						state_q <= S_UP;
					end else begin
						second_q <= 1'b0;
						state_q  <= second_q ? S_DN : S_WR;
					end
				end
				S_DN: begin
					best_id_q  <= e_id_q;
					best_key_q <= e_key_q;
					best_e_q   <= 1'b1;
					l_q        <= l_ext[SW-1:0];
					if (l_ext >= (CW + 1)'(count_q)) begin
						second_q <= 1'b0;
						state_q  <= second_q ? S_UP : S_WR;
					end else begin
						state_q <= S_DNL;
					end
				end
				S_DNL: begin
					if (cmp_above) begin
						best_id_q   <= rd_id;
						best_key_q  <= rd_key;
						best_slot_q <= l_q;
						best_e_q    <= 1'b0;
					end
					state_q <= (r_ext < (CW + 1)'(count_q)) ? S_DNR : S_DNM;
				end
				S_DNR: begin
					if (cmp_above) begin
						best_id_q   <= rd_id;
						best_key_q  <= rd_key;
						best_slot_q <= r_ext[SW-1:0];
						best_e_q    <= 1'b0;
					end
					state_q <= S_DNM;
				end
				S_DNM: begin
					if (best_e_q) begin
						second_q <= 1'b0;
						state_q  <= second_q ? S_UP : S_WR;
					end else begin
						s_q     <= best_slot_q;
						state_q <= S_DN;
					end
				end
				S_WR: state_q <= S_FIN;
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						top_id        <= res_tid_q;
						top_key       <= res_tkey_q;
						status        <= res_st_q;
						element_count <= ihb_pkg::CNTP_W'(count_q);
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/core/ihb_rank.sv]
// ----------------------------------------------------------------------------
// ihb_rank
// Shared rank compare: true when element a must sit nearer the top than b.
// ----------------------------------------------------------------------------
module ihb_rank #(
	parameter int IDW = 10
) (
	input  logic                           max_mode,
	input  logic [IDW-1:0]                 a_id,
	input  logic signed [ihb_pkg::KEY_W-1:0] a_key,
	input  logic [IDW-1:0]                 b_id,
	input  logic signed [ihb_pkg::KEY_W-1:0] b_key,
	output logic                           above
);

	always_comb begin
		if (a_key != b_key) begin
			above = max_mode ? (a_key > b_key) : (b_key > a_key);
		end else begin
			// equal keys: lower id wins in max mode, higher id in min mode
			above = max_mode ? (a_id < b_id) : (a_id > b_id);
		end
	end

endmodule
